FILE: sv/buffer_recycle_pool_core_defines.svh
// Assertion macros shared by the buffer pool checker.
`ifndef BUFFER_RECYCLE_POOL_CORE_DEFINES_SVH
`define BUFFER_RECYCLE_POOL_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BRP_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("buffer pool check failed");

// Next-cycle implication, ignored while reset is high.
`define BRP_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("buffer pool check failed");

// Next-cycle implication that also holds across reset.
`define BRP_ASSERT_NEXT_ALWAYS(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("buffer pool check failed");

`endif

FILE: sv/brp_pkg.sv
// Types and constants of the buffer recycle pool.
package brp_pkg;

  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_MISS   = 3'd1;
  localparam logic [2:0] KIND_KEPT   = 3'd2;
  localparam logic [2:0] KIND_REJECT = 3'd3;
  localparam logic [2:0] KIND_EVICT  = 3'd4;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_IDLE   = 1'b1;

  localparam logic [12:0] BUDGET_RESET = 13'd128;
  localparam logic [31:0] IDLE_RESET   = 32'd2000000;
  localparam int          MIB_LOG2     = 20;

  typedef struct packed {
    logic        mode;
    logic [39:0] size_bytes;
    logic [15:0] handle;
    logic [47:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_handle;
    logic [39:0] out_capacity;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [39:0] capacity;
    logic [47:0] stamp;
    logic [15:0] handle;
    logic [31:0] order;
  } entry_t;

  typedef enum logic [1:0] {
    SK_FIT,
    SK_IDLE,
    SK_OLD,
    SK_FREE
  } scan_kind_t;

  typedef enum logic [2:0] {
    PH_FIT,
    PH_IDLE,
    PH_OLD,
    PH_FREE,
    PH_FULL
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_POST,
    S_REMOVE,
    S_BUDGET,
    S_INSERT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       prim;
    logic       scan_start;
    scan_kind_t scan_kind;
    logic       take_fit;
    logic       remove;
    logic       insert;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic below_min;
    logic reject;
    logic give;
    logic found;
    logic hit;
    logic over;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/brp_ctrl.sv
// Sequencer of the buffer pool: drives scans, removals, insertion and result pushes.
module brp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  brp_pkg::stat_t stat,
  output brp_pkg::cmd_t  cmd
);

  brp_pkg::state_t state, state_next;
  brp_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brp_pkg::S_IDLE;
      phase <= brp_pkg::PH_FIT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      brp_pkg::S_IDLE: begin
        if (req_valid) state_next = brp_pkg::S_DECIDE;
      end
      brp_pkg::S_DECIDE: begin
        if (!stat.give) begin
          if (stat.below_min) begin
            state_next = brp_pkg::S_FINISH;
          end else begin
            state_next = brp_pkg::S_SCAN;
            phase_next = brp_pkg::PH_FIT;
          end
        end else if (stat.reject) begin
          state_next = brp_pkg::S_FINISH;
        end else begin
          state_next = brp_pkg::S_SCAN;
          phase_next = brp_pkg::PH_IDLE;
        end
      end
      brp_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = brp_pkg::S_POST;
      end
      brp_pkg::S_POST: begin
        case (phase)
          brp_pkg::PH_FIT: begin
            state_next = brp_pkg::S_SCAN;
            phase_next = brp_pkg::PH_IDLE;
          end
          brp_pkg::PH_IDLE: begin
            state_next = stat.found ? brp_pkg::S_REMOVE : brp_pkg::S_BUDGET;
          end
          brp_pkg::PH_OLD: begin
            if (stat.found) begin
              state_next = brp_pkg::S_REMOVE;
            end else if (stat.give) begin
              state_next = brp_pkg::S_SCAN;
              phase_next = brp_pkg::PH_FREE;
            end else begin
              state_next = brp_pkg::S_FINISH;
            end
          end
          brp_pkg::PH_FREE: begin
            if (stat.found) begin
              state_next = brp_pkg::S_INSERT;
            end else begin
              state_next = brp_pkg::S_SCAN;
              phase_next = brp_pkg::PH_FULL;
            end
          end
          default: state_next = brp_pkg::S_REMOVE;
        endcase
      end
      brp_pkg::S_REMOVE: begin
        if (stat.out_free) begin
          case (phase)
            brp_pkg::PH_IDLE: state_next = brp_pkg::S_SCAN;
            brp_pkg::PH_OLD:  state_next = brp_pkg::S_BUDGET;
            brp_pkg::PH_FULL: state_next = brp_pkg::S_INSERT;
            default:          state_next = brp_pkg::S_FINISH;
          endcase
        end
      end
      brp_pkg::S_BUDGET: begin
        if (stat.over) begin
          state_next = brp_pkg::S_SCAN;
          phase_next = brp_pkg::PH_OLD;
        end else if (stat.give) begin
          state_next = brp_pkg::S_SCAN;
          phase_next = brp_pkg::PH_FREE;
        end else begin
          state_next = brp_pkg::S_FINISH;
        end
      end
      brp_pkg::S_INSERT: state_next = brp_pkg::S_FINISH;
      brp_pkg::S_FINISH: begin
        if (stat.out_free) state_next = brp_pkg::S_IDLE;
      end
      default: state_next = brp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == brp_pkg::S_IDLE) && req_valid;
    cmd.prim       = (state == brp_pkg::S_DECIDE) && (stat.give || stat.below_min);
    cmd.scan_start = (state_next == brp_pkg::S_SCAN) && (state != brp_pkg::S_SCAN);
    case (phase_next)
      brp_pkg::PH_FIT:  cmd.scan_kind = brp_pkg::SK_FIT;
      brp_pkg::PH_IDLE: cmd.scan_kind = brp_pkg::SK_IDLE;
      brp_pkg::PH_FREE: cmd.scan_kind = brp_pkg::SK_FREE;
      default:          cmd.scan_kind = brp_pkg::SK_OLD;
    endcase
    cmd.take_fit = (state == brp_pkg::S_POST) && (phase == brp_pkg::PH_FIT);
    cmd.remove   = (state == brp_pkg::S_REMOVE) && stat.out_free;
    cmd.insert   = (state == brp_pkg::S_INSERT);
    cmd.finish   = (state == brp_pkg::S_FINISH) && stat.out_free;
    req_stall    = (state != brp_pkg::S_IDLE);
  end

endmodule

FILE: sv/brp_datapath.sv
// Entry table, scan comparators, byte accounting, registers and result register.
module brp_datapath #(
  parameter int ENTRIES        = 32,
  parameter int MIN_BYTES_LOG2 = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  brp_pkg::req_t  req,
  input  logic           cfg_valid,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_data,
  input  brp_pkg::cmd_t  cmd,
  output brp_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output brp_pkg::rsp_t  rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  brp_pkg::req_t      cur;
  logic [12:0]        budget_mib;
  logic [31:0]        idle_limit;
  logic [ENTRIES-1:0] valid;
  logic [31:0]        insert_counter;
  logic [47:0]        held;

  brp_pkg::entry_t    mem [ENTRIES];
  brp_pkg::entry_t    rd;
  logic               scan_run;
  logic [IW-1:0]      idx;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;
  brp_pkg::scan_kind_t kind;
  logic               found;
  brp_pkg::entry_t    best;
  logic [IW-1:0]      best_idx;
  brp_pkg::rsp_t      pend;

  logic [31:0] cand_age, best_age;
  logic        cap_before, old_before, is_idle, cand_v, take;
  logic [32:0] budget_bytes;
  logic [48:0] need;
  logic        out_free;

  always_comb begin
    cand_age   = insert_counter - rd.order;
    best_age   = insert_counter - best.order;
    cap_before = (rd.capacity < best.capacity) ||
                 ((rd.capacity == best.capacity) && (cand_age > best_age));
    old_before = (rd.stamp < best.stamp) || ((rd.stamp == best.stamp) && cap_before);
    is_idle    = (cur.now > rd.stamp) && ((cur.now - rd.stamp) > {16'b0, idle_limit});
    cand_v     = valid[cmp_idx];
    case (kind)
      brp_pkg::SK_FIT:  take = cand_v && (rd.capacity >= cur.size_bytes) &&
                               (!found || cap_before);
      brp_pkg::SK_IDLE: take = cand_v && is_idle && (!found || cap_before);
      brp_pkg::SK_OLD:  take = cand_v && (!found || old_before);
      brp_pkg::SK_FREE: take = !cand_v && !found;
      default:          take = 1'b0;
    endcase
    take = take && cmp_vld;

    budget_bytes = {budget_mib, 20'b0};
    need = {1'b0, held} + 49'(cur.mode ? cur.size_bytes : 40'd0);
    out_free = !rsp_valid || !rsp_stall;

    stat.below_min = (budget_mib == '0) || ((cur.size_bytes >> MIN_BYTES_LOG2) == '0);
    stat.reject    = stat.below_min || (cur.size_bytes > 40'(budget_bytes));
    stat.give      = cur.mode;
    stat.found     = found;
    stat.hit       = found && ((best.capacity >> 2) <= cur.size_bytes);
    stat.over      = need > 49'(budget_bytes);
    stat.scan_done = cmp_vld && (cmp_idx == LAST_IDX);
    stat.out_free  = out_free;
  end

  // Table memory: one write port for insertion, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem[best_idx] <= '{capacity: cur.size_bytes, stamp: cur.now,
                         handle: cur.handle, order: insert_counter};
    end
    rd <= mem[idx];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) cur <= req;
    if (take) begin
      best     <= rd;
      best_idx <= cmp_idx;
    end
    cmp_idx <= idx;
    if (cmd.prim) begin
      if (!cur.mode) begin
        pend <= '{kind: brp_pkg::KIND_MISS, out_handle: '0, out_capacity: '0, last: 1'b0};
      end else begin
        pend <= '{kind: stat.reject ? brp_pkg::KIND_REJECT : brp_pkg::KIND_KEPT,
                  out_handle: cur.handle, out_capacity: cur.size_bytes, last: 1'b0};
      end
    end else if (cmd.take_fit) begin
      if (stat.hit) begin
        pend <= '{kind: brp_pkg::KIND_HIT, out_handle: best.handle,
                  out_capacity: best.capacity, last: 1'b0};
      end else begin
        pend <= '{kind: brp_pkg::KIND_MISS, out_handle: '0, out_capacity: '0, last: 1'b0};
      end
    end else if (cmd.remove) begin
      pend <= '{kind: brp_pkg::KIND_EVICT, out_handle: best.handle,
                out_capacity: best.capacity, last: 1'b0};
    end
    if (cmd.remove || cmd.finish) begin
      rsp <= '{kind: pend.kind, out_handle: pend.out_handle,
               out_capacity: pend.out_capacity, last: cmd.finish};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget_mib     <= brp_pkg::BUDGET_RESET;
      idle_limit     <= brp_pkg::IDLE_RESET;
      valid          <= '0;
      insert_counter <= '0;
      held           <= '0;
      scan_run       <= 1'b0;
      idx            <= '0;
      cmp_vld        <= 1'b0;
      kind           <= brp_pkg::SK_FIT;
      found          <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          brp_pkg::CFG_BUDGET: budget_mib <= cfg_data[12:0];
          brp_pkg::CFG_IDLE:   idle_limit <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.scan_start) begin
        scan_run <= 1'b1;
        idx      <= '0;
        kind     <= cmd.scan_kind;
        found    <= 1'b0;
      end else begin
        if (scan_run) begin
          idx <= idx + IW'(1);
          if (idx == LAST_IDX) scan_run <= 1'b0;
        end
        if (take) found <= 1'b1;
      end
      cmp_vld <= scan_run && !cmd.scan_start;

      if ((cmd.take_fit && stat.hit) || cmd.remove) begin
        valid[best_idx] <= 1'b0;
        held            <= held - {8'b0, best.capacity};
      end else if (cmd.insert) begin
        valid[best_idx] <= 1'b1;
        held            <= held + {8'b0, cur.size_bytes};
        insert_counter  <= insert_counter + 32'd1;
      end

      if (cmd.remove || cmd.finish) rsp_valid <= 1'b1;
      else if (!rsp_stall)          rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/buffer_recycle_pool_core.sv
// Buffer recycle pool: top level joining the sequencer and the table datapath.
// The pool keeps up to ENTRIES idle buffers and serves one word at a time. A take
// finds the best fitting buffer, then evicts idle entries and, while the held bytes
// exceed the budget, the oldest ones; a give makes room in the same way and stores
// the buffer. Every table walk reads one entry per cycle from the entry memory.
// Evictions include the entry pushed out of a full table; small, disabled or
// rejected requests finish without a table walk. Each request yields its primary
// result word first, then one word per eviction, with last set on the final one.
// Results sit in an output register, so a new request is taken as soon as the
// final word has been loaded there. After reset the table is empty and no
// clearing pass is needed. The configuration port is always ready; index 0 writes
// the budget in MiB, index 1 the idle limit.
module buffer_recycle_pool_core #(
  parameter int ENTRIES        = 32,
  parameter int MIN_BYTES_LOG2 = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  brp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output brp_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  brp_pkg::cmd_t  cmd;
  brp_pkg::stat_t stat;

  // Registers can be written in any cycle.
  assign cfg_ready = 1'b1;

  brp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  brp_datapath #(
    .ENTRIES        (ENTRIES),
    .MIN_BYTES_LOG2 (MIN_BYTES_LOG2)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: sv/brp_checker.sv
// Port-level checks of the buffer pool and their attachment to the top level.
`include "buffer_recycle_pool_core_defines.svh"

module brp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input brp_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_stall
);

  `BRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `BRP_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
  `BRP_ASSERT_NOW(a_more_follows, rsp_valid && !rsp.last, req_stall)
  `BRP_ASSERT_NOW(a_kind_range, rsp_valid, rsp.kind <= brp_pkg::KIND_EVICT)
  `BRP_ASSERT_NEXT_ALWAYS(a_reset_quiet, rst, !rsp_valid)

endmodule

bind buffer_recycle_pool_core brp_checker u_brp_checker (.*);

FILE: bench/tb_buffer_recycle_pool_core.sv
// Self-checking testbench for the buffer recycle pool core.
module tb_buffer_recycle_pool_core;
  import brp_pkg::*;

  localparam int         SLOTS     = 32;
  localparam logic [39:0] MIB      = 40'd1 << MIB_LOG2;
  localparam int         STALL_MAX = 20000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Scoreboard: a private model of the pool table plus the words it still owes.
  class pool_scoreboard;
    bit          slot_used [SLOTS];
    logic [39:0] slot_cap [SLOTS];
    logic [47:0] slot_stamp [SLOTS];
    logic [15:0] slot_handle [SLOTS];
    logic [31:0] slot_order [SLOTS];
    logic [31:0] next_order;
    logic [47:0] held;
    logic [12:0] budget_mib;
    logic [31:0] idle_limit;
    rsp_t        owed_words [$];
    rsp_t        burst [$];
    int          errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 0;
      next_order = 0;
      held       = 0;
      budget_mib = BUDGET_RESET;
      idle_limit = IDLE_RESET;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_BUDGET) budget_mib = val[12:0];
      else idle_limit = val;
    endfunction

    function void emit(logic [2:0] k, logic [15:0] h, logic [39:0] c);
      rsp_t w;
      w.kind = k;
      w.out_handle = h;
      w.out_capacity = c;
      w.last = 1'b0;
      burst.push_back(w);
    endfunction

    // Larger age means inserted earlier; the subtraction wraps like the counter.
    function bit cap_first(int a, int b);
      logic [31:0] age_a;
      logic [31:0] age_b;
      age_a = next_order - slot_order[a];
      age_b = next_order - slot_order[b];
      if (slot_cap[a] != slot_cap[b]) return slot_cap[a] < slot_cap[b];
      return age_a > age_b;
    endfunction

    function bit old_first(int a, int b);
      if (slot_stamp[a] != slot_stamp[b]) return slot_stamp[a] < slot_stamp[b];
      return cap_first(a, b);
    endfunction

    function void drop(int i);
      slot_used[i] = 0;
      held = held - slot_cap[i];
      emit(KIND_EVICT, slot_handle[i], slot_cap[i]);
    endfunction

    function int oldest();
      int pick;
      pick = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && (pick < 0 || old_first(i, pick))) pick = i;
      return pick;
    endfunction

    // Idle entries go first, smallest capacity first; then the oldest while over budget.
    function void make_room(logic [39:0] extra, logic [47:0] now);
      longint unsigned limit_bytes;
      logic [47:0]     elapsed;
      int              pick;
      limit_bytes = longint'(budget_mib) << MIB_LOG2;
      forever begin
        pick = -1;
        for (int i = 0; i < SLOTS; i++) begin
          elapsed = (now >= slot_stamp[i]) ? now - slot_stamp[i] : 48'd0;
          if (slot_used[i] && elapsed > {16'd0, idle_limit} &&
              (pick < 0 || cap_first(i, pick))) pick = i;
        end
        if (pick < 0) break;
        drop(pick);
      end
      while (longint'(held) + longint'(extra) > limit_bytes) begin
        pick = oldest();
        if (pick < 0) break;
        drop(pick);
      end
    endfunction

    function void note_request(req_t r);
      longint unsigned limit_bytes;
      int              pick;
      limit_bytes = longint'(budget_mib) << MIB_LOG2;
      burst.delete();
      if (r.mode == 1'b0) begin
        if (budget_mib == 0 || r.size_bytes < MIB) begin
          emit(KIND_MISS, 16'd0, 40'd0);
        end else begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_cap[i] >= r.size_bytes &&
                (pick < 0 || cap_first(i, pick))) pick = i;
          if (pick >= 0 && (slot_cap[pick] >> 2) <= r.size_bytes) begin
            slot_used[pick] = 0;
            held = held - slot_cap[pick];
            emit(KIND_HIT, slot_handle[pick], slot_cap[pick]);
          end else begin
            emit(KIND_MISS, 16'd0, 40'd0);
          end
          make_room(40'd0, r.now);
        end
      end else begin
        if (budget_mib == 0 || r.size_bytes < MIB || longint'(r.size_bytes) > limit_bytes)
        begin
          emit(KIND_REJECT, r.handle, r.size_bytes);
        end else begin
          emit(KIND_KEPT, r.handle, r.size_bytes);
          make_room(r.size_bytes, r.now);
          pick = -1;
          for (int i = 0; i < SLOTS && pick < 0; i++)
            if (!slot_used[i]) pick = i;
          if (pick < 0) begin
            pick = oldest();
            drop(pick);
          end
          slot_used[pick]   = 1;
          slot_cap[pick]    = r.size_bytes;
          slot_stamp[pick]  = r.now;
          slot_handle[pick] = r.handle;
          slot_order[pick]  = next_order;
          next_order++;
          held = held + r.size_bytes;
        end
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) owed_words.push_back(burst[i]);
    endfunction

    task report(string what, rsp_t got, rsp_t want);
      $display("mismatch on %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (owed_words.size() == 0) begin
        report("unexpected word", got, '0);
        return;
      end
      want = owed_words.pop_front();
      if (got.kind != want.kind) report("kind", got, want);
      if (got.out_handle != want.out_handle) report("handle", got, want);
      if (got.out_capacity != want.out_capacity) report("capacity", got, want);
      if (got.last != want.last) report("last", got, want);
    endtask
  endclass

  pool_scoreboard pool_sb;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int          quiet_cycles;
  logic [47:0] clock_us;

  buffer_recycle_pool_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, and on request holds off for a long stretch
  // so that the block backs up and stalls its own input.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 400;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every accepted result word is checked against the oldest owed word.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) pool_sb.check_result(rsp);
  end

  // Watchdog: a long run of cycles with no word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word; valid stays high across back-to-back words.
  task send_request(req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pool_sb.note_request(r);
  endtask

  task send_fields(logic mode, logic [39:0] size, logic [15:0] h, logic [47:0] now);
    req_t r;
    r.mode = mode;
    r.size_bytes = size;
    r.handle = h;
    r.now = now;
    send_request(r);
  endtask

  // Drop valid and wait until every owed word has come back.
  task drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pool_sb.owed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_sb.set_reg(idx, val);
  endtask

  // Random words: mostly gives and takes of plausible sizes so the table fills,
  // evicts and hits, with some tiny, oversized and fully random sizes mixed in.
  task random_requests(int count);
    req_t        r;
    int          pick;
    logic [39:0] sz;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) sz = 40'($urandom_range(32'(MIB) - 32'd1));
      else if (pick < 14) sz = 40'({$urandom(), $urandom()});
      else sz = (MIB << $urandom_range(0, 6)) + 40'($urandom_range(32'(MIB) - 32'd1));
      pick = $urandom_range(99);
      if (pick < 3) clock_us = clock_us - 48'($urandom_range(500000));
      else if (pick < 5) clock_us = 48'({$urandom(), $urandom()});
      else clock_us = clock_us + 48'($urandom_range(400000));
      r.mode = 1'($urandom_range(1));
      r.size_bytes = sz;
      r.handle = 16'($urandom());
      r.now = clock_us;
      send_request(r);
    end
  endtask

  initial begin
    pool_sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BUDGET;
    cfg_data = '0;
    send_idle_pct = 6;
    recv_idle_pct = 85;
    hold_request = 0;
    quiet_cycles = 0;
    clock_us = 48'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings.
    send_fields(1'b0, MIB - 40'd1, 16'hFFFF, 48'd10);      // small take misses quietly
    send_fields(1'b0, MIB, 16'd0, 48'd10);                 // empty table, no fit
    send_fields(1'b1, 40'd0, 16'h1234, 48'd10);            // give below minimum
    send_fields(1'b1, 40'hFF_FFFF_FFFF, 16'hFFFF, 48'd10); // give above budget
    send_fields(1'b1, MIB, 16'd1, 48'd20);
    send_fields(1'b1, 40'd4 * MIB, 16'd2, 48'd30);
    send_fields(1'b1, 40'd4 * MIB, 16'd3, 48'd30);
    send_fields(1'b0, 40'd3 * MIB, 16'd0, 48'd40);         // best fit, earlier of equals
    send_fields(1'b0, MIB, 16'd0, 48'd40);                 // exact fit
    send_fields(1'b1, 40'd64 * MIB, 16'd4, 48'd50);
    send_fields(1'b0, 40'd2 * MIB, 16'd0, 48'd50);         // smallest fitting entry hits
    send_fields(1'b1, 40'd128 * MIB, 16'd5, 48'd60);       // full budget pushes out the rest
    send_fields(1'b1, 40'd2 * MIB, 16'd6, 48'd2000061);    // previous entry turns idle
    send_fields(1'b1, 40'd2 * MIB, 16'd7, 48'd5);          // time going backwards
    send_fields(1'b0, 40'd2 * MIB, 16'd0, 48'hFFFF_FFFF_FFFF); // everything idle
    drain();

    // Pool disabled.
    write_reg(CFG_BUDGET, 32'd0);
    send_fields(1'b1, 40'd2 * MIB, 16'd8, 48'd100);
    send_fields(1'b0, 40'd2 * MIB, 16'd0, 48'd100);
    drain();

    // A 4096 MiB budget, idle never expires: overfill the table.
    write_reg(CFG_BUDGET, 32'd4096);
    write_reg(CFG_IDLE, 32'hFFFF_FFFF);
    for (int i = 0; i < 36; i++)
      send_fields(1'b1, MIB + 40'(i[1:0]), 16'(32'h100 + i), 48'(200 + (i % 3)));
    send_fields(1'b1, {8'd1, 32'd0}, 16'hBEEF, 48'd300);  // exactly the budget
    drain();

    // Idle limit of zero and a one MiB budget.
    write_reg(CFG_IDLE, 32'd0);
    write_reg(CFG_BUDGET, 32'd1);
    clock_us = 48'd1000;
    random_requests(10);
    drain();

    // Back to reset-like settings; sender idles rarely, receiver often.
    write_reg(CFG_BUDGET, 32'd128);
    write_reg(CFG_IDLE, 32'd2000000);
    send_idle_pct = 6;
    recv_idle_pct = 85;
    random_requests(35);

    // Long receiver hold-off while the sender keeps pushing.
    hold_request = 1;
    random_requests(12);
    drain();

    write_reg(CFG_BUDGET, 32'd48);
    write_reg(CFG_IDLE, 32'd600000);
    send_idle_pct = 85;
    recv_idle_pct = 6;
    random_requests(30);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(20);
    drain();
    repeat (40) @(posedge clk);

    if (pool_sb.errors == 0 && pool_sb.owed_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
